// ===== rtl/core/irenc_pkg.sv =====
// ----------------------------------------------------------------------------
// irenc_pkg
// Shared types, character codes and digit tables for the Roman numeral
// encoder core.
// ----------------------------------------------------------------------------
package irenc_pkg;

    localparam int ValueWidth = 14;
    localparam int CharWidth  = 7;
    localparam int DigitWidth = 4;
    localparam int LenWidth   = 3;
    localparam int IdxWidth   = 3;
    localparam int PosWidth   = 2;
    localparam int NumDigits  = 4;
    localparam int MaxDigit   = 9;

    typedef logic [ValueWidth-1:0] value_t;
    typedef logic [CharWidth-1:0]  char_t;
    typedef logic [DigitWidth-1:0] digit_t;
    typedef logic [LenWidth-1:0]   len_t;
    typedef logic [IdxWidth-1:0]   idx_t;
    typedef logic [PosWidth-1:0]   pos_t;

    // ASCII codes of the numeral characters
    localparam char_t ChI   = 7'h49;
    localparam char_t ChV   = 7'h56;
    localparam char_t ChX   = 7'h58;
    localparam char_t ChL   = 7'h4C;
    localparam char_t ChC   = 7'h43;
    localparam char_t ChD   = 7'h44;
    localparam char_t ChM   = 7'h4D;
    localparam char_t ChBar = 7'h5F;

    // Decimal positions, most significant first
    localparam pos_t PosThousands = 2'd0;
    localparam pos_t PosHundreds  = 2'd1;
    localparam pos_t PosTens      = 2'd2;
    localparam pos_t PosOnes      = 2'd3;

    localparam value_t Modulus = 14'd10000;

    typedef struct packed {
        logic load;
        logic split;
        logic emit;
        logic skip;
    } dp_cmd_t;

    typedef struct packed {
        logic split_last;
        logic len_zero;
        logic char_last;
        logic pos_last;
        logic out_free;
    } dp_sts_t;

    // k times the place weight of a split step
    function automatic value_t place_multiple(pos_t step, digit_t k);
        value_t w;
        begin
            case (step)
                PosThousands: w = 14'd1000;
                PosHundreds:  w = 14'd100;
                default:      w = 14'd10;
            endcase
            return value_t'(32'(k) * 32'(w));
        end
    endfunction

    // Number of characters a digit produces at a position
    function automatic len_t digit_len(pos_t pos, digit_t d);
        len_t len;
        begin
            if (d == 4'd4 || d == 4'd9) begin
                len = (pos == PosThousands) ? 3'd3 : 3'd2;
            end else if (d >= 4'd5) begin
                len = (pos == PosThousands) ? len_t'(d - 4'd3) : len_t'(d - 4'd4);
            end else begin
                len = len_t'(d);
            end
            return len;
        end
    endfunction

    // Character j of the numeral for digit d at a position
    function automatic char_t digit_char(pos_t pos, digit_t d, idx_t j);
        char_t ch_one;
        char_t ch_five;
        char_t ch_ten;
        char_t ch;
        begin
            case (pos)
                PosThousands: begin ch_one = ChM; ch_five = ChV; ch_ten = ChX; end
                PosHundreds:  begin ch_one = ChC; ch_five = ChD; ch_ten = ChM; end
                PosTens:      begin ch_one = ChX; ch_five = ChL; ch_ten = ChC; end
                default:      begin ch_one = ChI; ch_five = ChV; ch_ten = ChX; end
            endcase
            if (pos == PosThousands) begin
                // overline written as a trailing underscore
                if (d == 4'd4) begin
                    ch = (j == 3'd0) ? ChM : ((j == 3'd1) ? ChV : ChBar);
                end else if (d == 4'd9) begin
                    ch = (j == 3'd0) ? ChM : ((j == 3'd1) ? ChX : ChBar);
                end else if (d >= 4'd5) begin
                    ch = (j == 3'd0) ? ChV : ((j == 3'd1) ? ChBar : ChM);
                end else begin
                    ch = ChM;
                end
            end else begin
                if (d == 4'd4) begin
                    ch = (j == 3'd0) ? ch_one : ch_five;
                end else if (d == 4'd9) begin
                    ch = (j == 3'd0) ? ch_one : ch_ten;
                end else if (d >= 4'd5) begin
                    ch = (j == 3'd0) ? ch_five : ch_one;
                end else begin
                    ch = ch_one;
                end
            end
            return ch;
        end
    endfunction

endpackage

// ===== rtl/core/irenc_datapath.sv =====
// ----------------------------------------------------------------------------
// irenc_datapath
// Digit split by one decimal place a cycle, then one numeral character a
// cycle into the output register while it is free; zero digits are skipped.
// ----------------------------------------------------------------------------
module irenc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  irenc_pkg::value_t  s_value,
    input  irenc_pkg::dp_cmd_t cmd,
    output irenc_pkg::dp_sts_t sts,
    input  logic               m_ready,
    output logic               m_valid,
    output irenc_pkg::char_t   m_character,
    output logic               m_last
);
    import irenc_pkg::*;

    value_t rem_reg,  rem_next;
    digit_t digit_reg [NumDigits];
    digit_t digit_next [NumDigits];
    pos_t   pos_reg,  pos_next;
    idx_t   idx_reg,  idx_next;
    logic   m_valid_reg, m_valid_next;
    char_t  m_character_reg, m_character_next;
    logic   m_last_reg, m_last_next;

    value_t wrapped;
    digit_t split_digit;
    value_t rem_split;
    digit_t cur_digit;
    len_t   cur_len;
    logic   digit_done;
    logic   later_zero;
    logic   out_free;

    // fold values above range back into four decimal digits
    assign wrapped = (s_value >= Modulus) ? value_t'(s_value - Modulus) : s_value;

    always_comb begin
        split_digit = '0;
        for (int i = 1; i <= MaxDigit; i++) begin
            if (rem_reg >= place_multiple(pos_reg, digit_t'(i))) begin
                split_digit = digit_t'(i);
            end
        end
    end

    assign rem_split  = value_t'(rem_reg - place_multiple(pos_reg, split_digit));
    assign cur_digit  = digit_reg[pos_reg];
    assign cur_len    = digit_len(pos_reg, cur_digit);
    assign digit_done = (idx_reg == idx_t'(cur_len - 3'd1));
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        later_zero = 1'b1;
        for (int p = 0; p < NumDigits; p++) begin
            if (pos_t'(p) > pos_reg && digit_reg[p] != '0) begin
                later_zero = 1'b0;
            end
        end
    end

    assign sts.split_last = (pos_reg == PosTens);
    assign sts.len_zero   = (cur_digit == '0);
    assign sts.char_last  = digit_done && later_zero;
    assign sts.pos_last   = (pos_reg == PosOnes);
    assign sts.out_free   = out_free;

    always_comb begin
        rem_next         = rem_reg;
        digit_next       = digit_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        m_valid_next     = m_valid_reg;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            rem_next = wrapped;
            pos_next = PosThousands;
            idx_next = '0;
        end else if (cmd.split) begin
            digit_next[pos_reg] = split_digit;
            rem_next            = rem_split;
            if (pos_reg == PosTens) begin
                // what is left is the ones digit
                digit_next[PosOnes] = digit_t'(rem_split);
                pos_next            = PosThousands;
            end else begin
                pos_next = pos_t'(pos_reg + 2'd1);
            end
        end else if (cmd.emit) begin
            m_valid_next     = 1'b1;
            m_character_next = digit_char(pos_reg, cur_digit, idx_reg);
            m_last_next      = digit_done && later_zero;
            if (digit_done) begin
                idx_next = '0;
                pos_next = pos_t'(pos_reg + 2'd1);
            end else begin
                idx_next = idx_t'(idx_reg + 3'd1);
            end
        end else if (cmd.skip) begin
            idx_next = '0;
            pos_next = pos_t'(pos_reg + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= PosThousands;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg         <= rem_next;
        digit_reg       <= digit_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

endmodule

// ===== rtl/core/irenc_ctrl.sv =====
// ----------------------------------------------------------------------------
// irenc_ctrl
// Sequencer: take a value, run the three split steps, then walk the digits
// issuing one character per free output slot.
// ----------------------------------------------------------------------------
module irenc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output irenc_pkg::dp_cmd_t cmd,
    input  irenc_pkg::dp_sts_t sts
);
    import irenc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                cmd.split = 1'b1;
                if (sts.split_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.len_zero) begin
                    // drop empty digits
                    cmd.skip = 1'b1;
                    if (sts.pos_last) begin
                        state_next = ST_IDLE;
                    end
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.char_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// ===== rtl/core/integer_to_roman_encoder_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_core
// Converts a value to its Roman numeral, streamed as ASCII characters.
// ----------------------------------------------------------------------------
// Each transaction on the s_ side carries a value; the numeral comes out on
// the m_ side one character per transaction, m_last marking the final one.
// Values above 9999 use their four low decimal digits; a zero value gives no
// output. Thousands of four and up use a trailing underscore as overline.
// A value is accepted, then split into its digits one decimal place per
// cycle through a shared compare bank. The digits are then walked, one
// character per free output slot, each zero digit reached being skipped;
// back-pressure on m_ready holds the walk. The output register lets the
// next value be taken while the last character still waits.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  irenc_pkg::value_t s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output irenc_pkg::char_t  m_character,
    output logic              m_last
);
    import irenc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    irenc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    irenc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to Roman numeral encoder core.
// ----------------------------------------------------------------------------
// Every value taken on the s_ side is expanded into its expected character
// stream by a scoreboard. Each character leaving on the m_ side is compared
// with the oldest expected one, character and last flag.
// Stimulus starts with a directed set: digit corners, every thousands form,
// the longest numeral, zero and values past 9999. A random part follows,
// with idle cycles on both sides, a calm stretch with none, a long receiver
// hold-off and a pause that lets the pipe drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irenc_pkg::*;

    localparam int StallLimit = 5000;
    localparam int HoldCycles = 400;
    localparam int DrainWait  = 25;
    localparam int IdlePct    = 19;

    class roman_scoreboard;
        typedef struct packed {
            char_t ch;
            logic  last;
        } numeral_char_t;

        numeral_char_t expected_q[$];
        int errors;
        int checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_char(char_t ch);
            numeral_char_t e;
            e.ch   = ch;
            e.last = 1'b0;
            expected_q.push_back(e);
        endfunction

        // standard form of one decimal place, subtractive for four and nine
        function void add_place(int d, char_t one, char_t five, char_t ten);
            int n;
            n = d;
            if (n == 4) begin
                add_char(one);
                add_char(five);
            end else if (n == 9) begin
                add_char(one);
                add_char(ten);
            end else begin
                if (n >= 5) begin
                    add_char(five);
                    n = n - 5;
                end
                repeat (n) add_char(one);
            end
        endfunction

        // thousands use a trailing underscore as overline from four upwards
        function void add_thousands(int d);
            if (d == 4) begin
                add_char(ChM);
                add_char(ChV);
                add_char(ChBar);
            end else if (d == 9) begin
                add_char(ChM);
                add_char(ChX);
                add_char(ChBar);
            end else if (d >= 5) begin
                add_char(ChV);
                add_char(ChBar);
                repeat (d - 5) add_char(ChM);
            end else begin
                repeat (d) add_char(ChM);
            end
        endfunction

        function void note_value(value_t v);
            int u;
            int start;
            numeral_char_t e;
            u     = int'(v) % 10000;
            start = expected_q.size();
            add_thousands(u / 1000);
            add_place((u / 100) % 10, ChC, ChD, ChM);
            add_place((u / 10) % 10, ChX, ChL, ChC);
            add_place(u % 10, ChI, ChV, ChX);
            if (expected_q.size() > start) begin
                e      = expected_q.pop_back();
                e.last = 1'b1;
                expected_q.push_back(e);
            end
        endfunction

        function void check_char(char_t ch, logic last);
            numeral_char_t e;
            checked++;
            if (expected_q.size() == 0) begin
                $error("unexpected transaction: character 0x%02h ('%c') last %0b",
                       ch, ch, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (ch !== e.ch) begin
                $error("character: expected 0x%02h ('%c'), actual 0x%02h ('%c')",
                       e.ch, e.ch, ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    value_t s_value = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    char_t  m_character;
    logic   m_last;

    roman_scoreboard sb = new();

    logic calm       = 1'b0;
    int   hold_asked = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   quiet      = 0;
    int   n_values   = 0;
    int   n_over     = 0;
    int   n_zero     = 0;

    integer_to_roman_encoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: random back-pressure, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HoldCycles;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_character, m_last);
        end
    end

    // abandon the run if neither side moves a transaction for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= StallLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_value(input value_t v);
        while (!calm && $urandom_range(0, 99) < IdlePct) begin
            s_valid <= 1'b0;
            s_value <= value_t'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_value(v);
        n_values++;
        if (v > 14'd9999) n_over++;
        if (v == '0) n_zero++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic value_t random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return value_t'($urandom_range(10000, 16383));
        if (r < 13) return '0;
        return value_t'($urandom_range(1, 9999));
    endfunction

    initial begin
        value_t directed[] = '{
            14'd0, 14'd1, 14'd4, 14'd5, 14'd9, 14'd40, 14'd49, 14'd90,
            14'd400, 14'd900, 14'd1994, 14'd3888, 14'd3999, 14'd4000,
            14'd4444, 14'd5000, 14'd6789, 14'd7006, 14'd8888, 14'd9000,
            14'd9999, 14'd10000, 14'd12345, 14'd16383
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_value(directed[i]);

        // hold the sender until every character so far has left
        drain();

        repeat (140) send_value(random_value());

        calm <= 1'b1;
        repeat (80) send_value(random_value());
        calm <= 1'b0;

        // stall the receiver while values keep coming so the input backs up
        hold_asked <= hold_asked + 1;
        repeat (40) send_value(random_value());

        repeat (86) send_value(random_value());

        drain();
        repeat (DrainWait) @(posedge aclk);

        $display("Run covered %0d values (%0d above 9999, %0d zero), %0d characters checked,",
                 n_values, n_over, n_zero, sb.checked);
        $display("with random idling, a calm stretch, one long receiver hold-off and drains.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
